### hw/rtl/pcc_pkg.sv
// Package for the PID controller with clamped integral term.
// Holds the configuration register map, the register bundle type and the field widths.
// Used by pcc_cfg_regs, pcc_core and pid_controller_clamped_integral.
package pcc_pkg;

  localparam int unsigned FracBits  = 12;
  localparam int unsigned GainW     = 18;
  localparam int unsigned LimitW    = 31;
  localparam int unsigned ErrW      = 16;
  localparam int unsigned DriveW    = 32;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 4;

  // Register indexes; byte address is four times the index.
  typedef enum logic [1:0] {
    REG_KP_GAIN        = 2'd0,
    REG_KI_GAIN        = 2'd1,
    REG_KD_GAIN        = 2'd2,
    REG_INTEGRAL_LIMIT = 2'd3
  } pcc_reg_e;

  // Register contents as seen by the datapath.
  typedef struct packed {
    logic signed [GainW-1:0] kp_gain;
    logic signed [GainW-1:0] ki_gain;
    logic signed [GainW-1:0] kd_gain;
    logic [LimitW-1:0]       integral_limit;
  } pcc_cfg_t;

endpackage

### hw/rtl/pcc_cfg_regs.sv
// APB register file for the PID controller: gains and integral limit.
// Depends on pcc_pkg for the register map and the register bundle type.
module pcc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcc_pkg::ApbAddrW-1:0]      paddr,
  input  logic [pcc_pkg::ApbDataW-1:0]      pwdata,
  output logic [pcc_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready,
  output pcc_pkg::pcc_cfg_t                 cfg_o
);
  import pcc_pkg::*;

  pcc_cfg_t cfg_q, cfg_d;
  pcc_reg_e reg_idx;
  logic     wr_en;

  // The word index comes from the upper address bits; byte offsets are ignored.
  assign reg_idx = pcc_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Next register values on a completed write transfer.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_KP_GAIN:        cfg_d.kp_gain        = pwdata[GainW-1:0];
        REG_KI_GAIN:        cfg_d.ki_gain        = pwdata[GainW-1:0];
        REG_KD_GAIN:        cfg_d.kd_gain        = pwdata[GainW-1:0];
        REG_INTEGRAL_LIMIT: cfg_d.integral_limit = pwdata[LimitW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read data: gains are sign-extended to the bus width.
  always_comb begin
    unique case (reg_idx)
      REG_KP_GAIN:        prdata = ApbDataW'(cfg_q.kp_gain);
      REG_KI_GAIN:        prdata = ApbDataW'(cfg_q.ki_gain);
      REG_KD_GAIN:        prdata = ApbDataW'(cfg_q.kd_gain);
      REG_INTEGRAL_LIMIT: prdata = ApbDataW'(cfg_q.integral_limit);
    endcase
  end

  assign cfg_o = cfg_q;

  // A write transfer lands in the addressed register on the next cycle.
  a_kp_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && reg_idx == REG_KP_GAIN) |=> cfg_q.kp_gain == $past(pwdata[GainW-1:0]))
    else $error("kp_gain write lost");
  a_limit_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && reg_idx == REG_INTEGRAL_LIMIT)
      |=> cfg_q.integral_limit == $past(pwdata[LimitW-1:0]))
    else $error("integral_limit write lost");
  a_no_write_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en |=> $stable(cfg_q))
    else $error("register changed without a write transfer");

endmodule

### hw/rtl/pcc_core.sv
// PID arithmetic and controller state: three gain products, clamped integral, saturated sum.
// Depends on pcc_pkg for widths and the register bundle type.
module pcc_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pcc_pkg::pcc_cfg_t                 cfg_i,
  input  logic signed [pcc_pkg::ErrW-1:0]   error_sample_i,
  input  logic                              advance_i,
  output logic signed [pcc_pkg::DriveW-1:0] drive_value_o
);
  import pcc_pkg::*;

  localparam int unsigned NegW  = ErrW + 1;           // negated sample, holds +32768
  localparam int unsigned DiffW = NegW + 1;
  localparam int unsigned PW    = GainW + NegW;       // 35-bit products
  localparam int unsigned DW    = GainW + DiffW;      // 36-bit product
  localparam int unsigned PTW   = PW - FracBits;      // 23-bit terms
  localparam int unsigned DTW   = DW - FracBits;      // 24-bit term
  localparam int unsigned AccW  = DriveW + 1;
  localparam int unsigned SumW  = DriveW + 2;

  logic signed [NegW-1:0]   prev_err_q;
  logic signed [DriveW-1:0] integral_q, integral_d;
  logic                     started_q;

  logic signed [NegW-1:0]   neg_err;
  logic signed [DiffW-1:0]  err_diff;
  logic signed [PW-1:0]     p_prod, i_prod;
  logic signed [DW-1:0]     d_prod;
  logic signed [PTW-1:0]    p_term, i_add;
  logic signed [DTW-1:0]    d_term;
  logic signed [AccW-1:0]   acc, lim_pos, lim_neg, acc_clamped;
  logic signed [SumW-1:0]   sum;

  // Negate the sample and take the change since the previous one.
  assign neg_err  = -NegW'(error_sample_i);
  assign err_diff = DiffW'(neg_err) - DiffW'(prev_err_q);

  // Exact products, brought back to 12 fractional bits by flooring.
  assign p_prod = PW'(cfg_i.kp_gain) * PW'(neg_err);
  assign i_prod = PW'(cfg_i.ki_gain) * PW'(neg_err);
  assign d_prod = DW'(cfg_i.kd_gain) * DW'(err_diff);
  assign p_term = p_prod[PW-1:FracBits];
  assign i_add  = i_prod[PW-1:FracBits];
  assign d_term = started_q ? d_prod[DW-1:FracBits] : '0;

  // Integral accumulate and clamp; the first sample loads the increment as is.
  assign acc     = AccW'(integral_q) + AccW'(i_add);
  assign lim_pos = AccW'({1'b0, cfg_i.integral_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if (acc > lim_pos) begin
      acc_clamped = lim_pos;
    end else if (acc < lim_neg) begin
      acc_clamped = lim_neg;
    end else begin
      acc_clamped = acc;
    end
    integral_d = started_q ? acc_clamped[DriveW-1:0] : DriveW'(i_add);
  end

  // Sum of the three terms, saturated to the output range.
  assign sum = SumW'(p_term) + SumW'(integral_d) + SumW'(d_term);

  always_comb begin
    priority if (sum > $signed(SumW'({1'b0, {(DriveW-1){1'b1}}}))) begin
      drive_value_o = {1'b0, {(DriveW-1){1'b1}}};
    end else if (sum < -$signed(SumW'({1'b1, {(DriveW-1){1'b0}}}))) begin
      drive_value_o = {1'b1, {(DriveW-1){1'b0}}};
    end else begin
      drive_value_o = sum[DriveW-1:0];
    end
  end

  // Controller state moves on with every sample that is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integral_q <= '0;
      started_q  <= 1'b0;
    end else if (advance_i) begin
      prev_err_q <= neg_err;
      integral_q <= integral_d;
      started_q  <= 1'b1;
    end
  end

  // Once started, every accumulate leaves the integral within the limit.
  a_integral_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && started_q) |=>
      (AccW'(integral_q) <= $signed(AccW'({1'b0, $past(cfg_i.integral_limit)})) &&
       AccW'(integral_q) >= -$signed(AccW'({1'b0, $past(cfg_i.integral_limit)}))))
    else $error("integral term outside its limit");
  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag dropped");
  a_first_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && !started_q) |=> started_q && integral_q == DriveW'($past(i_add)))
    else $error("first sample did not load the integral increment");
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> ($stable(integral_q) && $stable(prev_err_q)))
    else $error("state changed without a processed sample");

endmodule

### hw/rtl/pid_controller_clamped_integral.sv
// Top level of the PID controller with clamped integral: input register, core, result register.
// Depends on pcc_pkg, pcc_cfg_regs and pcc_core.
//
//   channel   direction  width  contents
//   s_axis    in         16     error_sample (signed, 12 fractional bits)
//   m_axis    out        32     drive_value (signed, 12 fractional bits, saturated)
//   apb       in/out     32     kp_gain 0x0, ki_gain 0x4, kd_gain 0x8, integral_limit 0xC
//
// One sample per cycle while results are taken; each passes the input and result registers.
// The arithmetic is one pass between the input register and the result register.
// Reset clears the gains, the limit, the integral, the previous error and both valid flags.
// A stalled result holds in the result register; the input register still takes a sample
// in the same cycle as the result is taken, so full rate is kept under a steady tready.
module pid_controller_clamped_integral (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Sample input.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pcc_pkg::ErrW-1:0]        s_axis_tdata,   // [15:0] error_sample
  // Result output.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pcc_pkg::DriveW-1:0]      m_axis_tdata,   // [31:0] drive_value
  // Configuration.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcc_pkg::ApbAddrW-1:0]    paddr,
  input  logic [pcc_pkg::ApbDataW-1:0]    pwdata,
  output logic [pcc_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);
  import pcc_pkg::*;

  pcc_cfg_t                 cfg;
  logic                     in_valid_q;
  logic signed [ErrW-1:0]   in_data_q;
  logic                     out_valid_q;
  logic [DriveW-1:0]        out_data_q;
  logic signed [DriveW-1:0] drive_value;
  logic                     advance;

  pcc_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The held sample is processed when the result register is free or being emptied.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  pcc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .error_sample_i (in_data_q),
    .advance_i      (advance),
    .drive_value_o  (drive_value)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= drive_value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A processed sample always shows up as a result on the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid && m_axis_tdata == $past(drive_value))
    else $error("processed sample produced no result");
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked result");
  a_held_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(in_data_q))
    else $error("waiting sample lost");

endmodule
